// ===== hdl/sahpwm_pkg.sv =====
// ----------------------------------------------------------------------------
// Six-axis H-bridge PWM drive package
// Shared types and constants for the sign-magnitude PWM drive core.
// ----------------------------------------------------------------------------
package sahpwm_pkg;

    localparam int AXIS_COUNT = 6;
    localparam int PIN_WIDTH = 6;
    localparam int AXIS_WIDTH = 3;
    localparam int DRIVE_WIDTH = 16;
    localparam int MASK_WIDTH = 8;
    localparam int COUNT_WIDTH = 16;
    localparam int MAG_WIDTH = 15;
    localparam int FRAC_BITS = 14;
    localparam int PRODUCT_WIDTH = MAG_WIDTH + COUNT_WIDTH;

    localparam int S_TDATA_WIDTH = 32;
    localparam int M_TDATA_WIDTH = 24;

    localparam logic [COUNT_WIDTH-1:0] PERIOD_RESET = 16'd5000;
    localparam logic [PIN_WIDTH-1:0] ARM_MASK_BITS = 6'h3F;
    localparam logic signed [DRIVE_WIDTH-1:0] FULL_SCALE_POS = 16'sd16384;
    localparam logic signed [DRIVE_WIDTH-1:0] FULL_SCALE_NEG = -16'sd16384;
    localparam logic [MAG_WIDTH-1:0] FULL_SCALE_MAG = 15'd16384;

    typedef enum logic [1:0] {
        CMD_SET_OUTPUT = 2'd0,
        CMD_ARM        = 2'd1,
        CMD_STOP       = 2'd2,
        CMD_TICK       = 2'd3
    } cmd_t;

    typedef logic [COUNT_WIDTH-1:0] compare_t;

endpackage

// ===== hdl/six_axis_hbridge_pwm_drive_core.sv =====
// ----------------------------------------------------------------------------
// Six-axis H-bridge PWM drive core
// Sign-magnitude PWM for six bridges with a shared up-counter, shadow and
// active compares, arm and stop control, and one status result per command.
// ----------------------------------------------------------------------------
// Pipeline: a command is held in the input register and its result is
// registered in the output register, which drives m_tvalid and m_tdata;
// a result moves on only while that register is empty or being read.
// Throughput: one command per cycle; a stalled result holds the input register
// and drops s_tready until m_tready returns.
// Reset: aresetn clears the counter, compares, pin state and pipeline valids and loads period 5000.
// ----------------------------------------------------------------------------
module six_axis_hbridge_pwm_drive_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sahpwm_pkg::COUNT_WIDTH-1:0]  cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // Fields from bit 0: axis[2:0], drive[18:3], arm_bits[26:19], zero fill.
    input  logic [sahpwm_pkg::S_TDATA_WIDTH-1:0] s_tdata,
    // Fields from bit 0: command[1:0].
    input  logic [1:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // Fields from bit 0: pwm_pins[5:0], direction_pins[11:6],
    // standby_pins[17:12], bridge_enable[18], zero fill.
    output logic [sahpwm_pkg::M_TDATA_WIDTH-1:0] m_tdata
);

    localparam int AC = sahpwm_pkg::AXIS_COUNT;
    localparam int PW = sahpwm_pkg::PIN_WIDTH;
    localparam int CW = sahpwm_pkg::COUNT_WIDTH;

    logic [CW-1:0]                          period_reg;
    logic [CW-1:0]                          counter_reg;
    logic [CW-1:0]                          counter_next;
    sahpwm_pkg::compare_t                   shadow_reg [AC];
    sahpwm_pkg::compare_t                   shadow_next [AC];
    sahpwm_pkg::compare_t                   active_reg [AC];
    sahpwm_pkg::compare_t                   active_next [AC];
    logic [AC-1:0]                          dir_reg;
    logic [AC-1:0]                          dir_next;
    logic [AC-1:0]                          standby_reg;
    logic [AC-1:0]                          standby_next;
    logic                                   enable_reg;
    logic                                   enable_next;

    logic                                   in_valid_reg;
    sahpwm_pkg::cmd_t                       in_cmd_reg;
    logic [sahpwm_pkg::AXIS_WIDTH-1:0]      in_axis_reg;
    logic signed [sahpwm_pkg::DRIVE_WIDTH-1:0] in_drive_reg;
    logic [sahpwm_pkg::MASK_WIDTH-1:0]      in_mask_reg;

    logic                                   out_valid_reg;
    logic [sahpwm_pkg::M_TDATA_WIDTH-1:0]   out_data_reg;
    logic [sahpwm_pkg::M_TDATA_WIDTH-1:0]   out_data_next;

    logic                                   advance;
    logic [sahpwm_pkg::MAG_WIDTH-1:0]       mag;
    logic [sahpwm_pkg::PRODUCT_WIDTH-1:0]   product;
    sahpwm_pkg::compare_t                   set_compare;
    logic [AC-1:0]                          arm_mask;
    logic [AC-1:0]                          pwm_bits;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    always_comb begin
        if (in_drive_reg > sahpwm_pkg::FULL_SCALE_POS ||
            in_drive_reg < sahpwm_pkg::FULL_SCALE_NEG) begin
            mag = sahpwm_pkg::FULL_SCALE_MAG;
        end else if (in_drive_reg < 0) begin
            mag = sahpwm_pkg::MAG_WIDTH'(-in_drive_reg);
        end else begin
            mag = sahpwm_pkg::MAG_WIDTH'(in_drive_reg);
        end
        product = sahpwm_pkg::PRODUCT_WIDTH'(mag) * sahpwm_pkg::PRODUCT_WIDTH'(period_reg);
        set_compare = product[sahpwm_pkg::FRAC_BITS +: CW];
        arm_mask = AC'(in_mask_reg) & AC'(sahpwm_pkg::ARM_MASK_BITS);
    end

    always_comb begin
        counter_next = counter_reg;
        dir_next     = dir_reg;
        standby_next = standby_reg;
        enable_next  = enable_reg;
        for (int k = 0; k < AC; k++) begin
            shadow_next[k] = shadow_reg[k];
            active_next[k] = active_reg[k];
        end
        unique case (in_cmd_reg)
            sahpwm_pkg::CMD_SET_OUTPUT: begin
                for (int k = 0; k < AC; k++) begin
                    if (32'(in_axis_reg) == k) begin
                        shadow_next[k] = set_compare;
                        dir_next[k]    = (in_drive_reg > 0);
                    end
                end
            end
            sahpwm_pkg::CMD_ARM: begin
                for (int k = 0; k < AC; k++) begin
                    shadow_next[k] = '0;
                end
                dir_next     = '0;
                standby_next = arm_mask;
                enable_next  = (arm_mask != '0);
            end
            sahpwm_pkg::CMD_STOP: begin
                for (int k = 0; k < AC; k++) begin
                    shadow_next[k] = '0;
                end
                dir_next     = '0;
                standby_next = '0;
                enable_next  = 1'b0;
            end
            sahpwm_pkg::CMD_TICK: begin
                if (counter_reg >= period_reg) begin
                    counter_next = '0;
                    for (int k = 0; k < AC; k++) begin
                        active_next[k] = shadow_reg[k];
                    end
                end else begin
                    counter_next = counter_reg + 1'b1;
                end
            end
        endcase
        for (int k = 0; k < AC; k++) begin
            pwm_bits[k] = (counter_next < active_next[k]);
        end
        out_data_next = '0;
        out_data_next[0 +: PW]      = PW'(pwm_bits);
        out_data_next[PW +: PW]     = PW'(dir_next);
        out_data_next[2*PW +: PW]   = PW'(standby_next);
        out_data_next[3*PW]         = enable_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg    <= sahpwm_pkg::PERIOD_RESET;
            counter_reg   <= '0;
            dir_reg       <= '0;
            standby_reg   <= '0;
            enable_reg    <= 1'b0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < AC; k++) begin
                shadow_reg[k] <= '0;
                active_reg[k] <= '0;
            end
        end else begin
            if (cfg_valid && cfg_ready) begin
                period_reg <= cfg_data;
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                counter_reg   <= counter_next;
                dir_reg       <= dir_next;
                standby_reg   <= standby_next;
                enable_reg    <= enable_next;
                for (int k = 0; k < AC; k++) begin
                    shadow_reg[k] <= shadow_next[k];
                    active_reg[k] <= active_next[k];
                end
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_cmd_reg   <= sahpwm_pkg::cmd_t'(s_tuser);
            in_axis_reg  <= s_tdata[2:0];
            in_drive_reg <= s_tdata[18:3];
            in_mask_reg  <= s_tdata[26:19];
        end
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

// ===== tb/sv/tb_six_axis_hbridge_pwm_drive_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Six-axis H-bridge PWM drive core testbench
// Streams set-output, arm, stop and tick commands into the core under random
// sender gaps and receiver stalls. A scoreboard tracks the counter, shadow and
// active compares, direction, standby and enable bits. It checks every status
// transfer field by field against the status that the command should leave.
// The period register is rewritten between phases, covering periods of 1 and
// 65535 and a period lowered below a running counter.
// ----------------------------------------------------------------------------
module tb_six_axis_hbridge_pwm_drive_core;
    import sahpwm_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int PHASE_COUNT = 9;
    localparam int PHASE_ITEMS = 92;

    typedef struct packed {
        logic                 enable;
        logic [PIN_WIDTH-1:0] standby;
        logic [PIN_WIDTH-1:0] direction;
        logic [PIN_WIDTH-1:0] pwm;
    } pin_status_t;

    class drive_status_scoreboard;
        int unsigned  period;
        compare_t     counter;
        compare_t     shadow[AXIS_COUNT];
        compare_t     active[AXIS_COUNT];
        logic [PIN_WIDTH-1:0] dir_bits;
        logic [PIN_WIDTH-1:0] standby_bits;
        logic         enable_bit;
        pin_status_t  expected_status[$];
        int           mismatches;
        int           statuses_checked;
        int           wraps;
        int           command_count[4];

        function new();
            period = PERIOD_RESET;
            counter = '0;
            foreach (shadow[k]) begin
                shadow[k] = '0;
                active[k] = '0;
            end
            dir_bits = '0;
            standby_bits = '0;
            enable_bit = 1'b0;
            mismatches = 0;
            statuses_checked = 0;
            wraps = 0;
            foreach (command_count[k]) command_count[k] = 0;
        endfunction

        function void set_period(logic [COUNT_WIDTH-1:0] value);
            period = value;
        endfunction

        function void clear_drives();
            foreach (shadow[k]) shadow[k] = '0;
            dir_bits = '0;
        endfunction

        function void note_command(cmd_t cmd, logic [AXIS_WIDTH-1:0] axis,
                                   logic signed [DRIVE_WIDTH-1:0] drive,
                                   logic [MASK_WIDTH-1:0] mask);
            int level;
            int unsigned magnitude;
            logic [PIN_WIDTH-1:0] armed;
            pin_status_t status;
            command_count[cmd]++;
            case (cmd)
                CMD_SET_OUTPUT: begin
                    if (axis < AXIS_COUNT) begin
                        level = drive;
                        if (level > 16384) level = 16384;
                        if (level < -16384) level = -16384;
                        magnitude = (level < 0) ? -level : level;
                        dir_bits[axis] = (level > 0);
                        shadow[axis] = compare_t'((magnitude * period) >> FRAC_BITS);
                    end
                end
                CMD_ARM: begin
                    armed = mask[PIN_WIDTH-1:0] & ARM_MASK_BITS;
                    clear_drives();
                    standby_bits = armed;
                    enable_bit = (armed != '0);
                end
                CMD_STOP: begin
                    clear_drives();
                    standby_bits = '0;
                    enable_bit = 1'b0;
                end
                default: begin
                    if (counter >= period) begin
                        counter = '0;
                        active = shadow;
                        wraps++;
                    end else begin
                        counter = counter + 1'b1;
                    end
                end
            endcase
            for (int k = 0; k < PIN_WIDTH; k++) status.pwm[k] = (counter < active[k]);
            status.direction = dir_bits;
            status.standby = standby_bits;
            status.enable = enable_bit;
            expected_status.push_back(status);
        endfunction

        function int pending();
            return expected_status.size();
        endfunction

        task report_mismatch(string what, int unsigned got, int unsigned want);
            mismatches++;
            $display("[%0t] mismatch in %s: got 0x%0h, expected 0x%0h", $realtime, what,
                     got, want);
        endtask

        task check_status(logic [M_TDATA_WIDTH-1:0] data);
            pin_status_t got;
            pin_status_t want;
            got = pin_status_t'(data[$bits(pin_status_t)-1:0]);
            if (expected_status.size() == 0) begin
                report_mismatch("status with none outstanding", data, 0);
                return;
            end
            want = expected_status.pop_front();
            statuses_checked++;
            if (got.pwm != want.pwm) report_mismatch("pwm_pins", got.pwm, want.pwm);
            if (got.direction != want.direction)
                report_mismatch("direction_pins", got.direction, want.direction);
            if (got.standby != want.standby)
                report_mismatch("standby_pins", got.standby, want.standby);
            if (got.enable != want.enable)
                report_mismatch("bridge_enable", got.enable, want.enable);
        endtask
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [COUNT_WIDTH-1:0] cfg_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_TDATA_WIDTH-1:0] s_tdata = '0;
    logic [1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_TDATA_WIDTH-1:0] m_tdata;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int quiet_cycles = 0;
    int phase_period[PHASE_COUNT] = '{3, 65535, 1, 40, 6, 11, 65535, 2, 25};
    drive_status_scoreboard board;

    six_axis_hbridge_pwm_drive_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) board.check_status(m_tdata);
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_six_axis_hbridge_pwm_drive_core failed");
            $finish;
        end
    end

    task automatic send_command(cmd_t cmd, logic [AXIS_WIDTH-1:0] axis,
                                logic [DRIVE_WIDTH-1:0] drive, logic [MASK_WIDTH-1:0] mask);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {{(S_TDATA_WIDTH - AXIS_WIDTH - DRIVE_WIDTH - MASK_WIDTH){1'b0}},
                    mask, drive, axis};
        do @(posedge aclk); while (!s_tready);
        board.note_command(cmd, axis, drive, mask);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_period(logic [COUNT_WIDTH-1:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        board.set_period(value);
    endtask

    task automatic send_random_commands(int count);
        cmd_t cmd;
        logic [AXIS_WIDTH-1:0] axis;
        logic [DRIVE_WIDTH-1:0] drive;
        logic [MASK_WIDTH-1:0] mask;
        int pick;
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 55) cmd = CMD_TICK;
            else if (pick < 92) cmd = CMD_SET_OUTPUT;
            else if (pick < 97) cmd = CMD_ARM;
            else cmd = CMD_STOP;
            axis = ($urandom_range(99) < 90) ? AXIS_WIDTH'($urandom_range(5))
                                              : AXIS_WIDTH'($urandom_range(7));
            pick = $urandom_range(99);
            if (pick < 15) begin
                case ($urandom_range(6))
                    0: drive = 16'sd16384;
                    1: drive = -16'sd16384;
                    2: drive = 16'sd32767;
                    3: drive = 16'h8000;
                    4: drive = 16'sd1;
                    5: drive = -16'sd1;
                    default: drive = '0;
                endcase
            end else if (pick < 70) begin
                drive = DRIVE_WIDTH'(int'($urandom_range(32768)) - 16384);
            end else begin
                drive = DRIVE_WIDTH'($urandom);
            end
            mask = ($urandom_range(99) < 10) ? MASK_WIDTH'($urandom_range(3) << 6)
                                              : MASK_WIDTH'($urandom);
            send_command(cmd, axis, drive, mask);
        end
    endtask

    initial begin
        board = new();
        send_idle_pct = 36;
        recv_stall_pct = 78;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Shadow compares are computed with the reset period and loaded later.
        send_command(CMD_ARM, 3'd0, 16'd0, 8'hFF);
        send_command(CMD_SET_OUTPUT, 3'd0, 16'sd16384, 8'h00);
        send_command(CMD_SET_OUTPUT, 3'd1, 16'sd32767, 8'h00);
        send_command(CMD_SET_OUTPUT, 3'd2, 16'h8000, 8'h00);
        send_command(CMD_SET_OUTPUT, 3'd3, -16'sd16385, 8'h00);
        send_command(CMD_SET_OUTPUT, 3'd4, 16'sd1, 8'h00);
        send_command(CMD_SET_OUTPUT, 3'd5, -16'sd1, 8'h00);
        send_command(CMD_SET_OUTPUT, 3'd6, 16'sd16384, 8'h00);
        send_command(CMD_SET_OUTPUT, 3'd7, 16'h5555, 8'h00);
        send_command(CMD_TICK, 3'd0, 16'd0, 8'h00);
        send_command(CMD_TICK, 3'd0, 16'd0, 8'h00);

        write_period(16'd4);
        repeat (5) send_command(CMD_TICK, 3'd0, 16'd0, 8'h00);
        send_command(CMD_SET_OUTPUT, 3'd0, 16'd0, 8'h00);
        send_command(CMD_ARM, 3'd0, 16'd0, 8'h40);
        send_command(CMD_TICK, 3'd7, 16'hFFFF, 8'hFF);
        send_command(CMD_ARM, 3'd0, 16'd0, 8'hC1);
        send_command(CMD_SET_OUTPUT, 3'd0, 16'sd8192, 8'h00);
        send_command(CMD_STOP, 3'd0, 16'd0, 8'h00);
        send_command(CMD_TICK, 3'd0, 16'd0, 8'h00);

        for (int p = 0; p < PHASE_COUNT; p++) begin
            write_period(COUNT_WIDTH'(phase_period[p]));
            if (p == 3) begin
                send_idle_pct = 78;
                recv_stall_pct = 36;
            end else if (p == 6) begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            send_random_commands(PHASE_ITEMS);
        end

        drain();
        repeat (8) @(posedge aclk);
        if (board.pending() != 0)
            board.report_mismatch("statuses never delivered", board.pending(), 0);
        $display("Checked %0d statuses: %0d set-output, %0d arm, %0d stop, %0d tick commands.",
                 board.statuses_checked, board.command_count[CMD_SET_OUTPUT],
                 board.command_count[CMD_ARM], board.command_count[CMD_STOP],
                 board.command_count[CMD_TICK]);
        $display("The counter wrapped %0d times over %0d period settings from 1 to 65535.",
                 board.wraps, PHASE_COUNT + 2);
        if (board.mismatches == 0) begin
            $display("tb_six_axis_hbridge_pwm_drive_core passed");
        end else begin
            $display("tb_six_axis_hbridge_pwm_drive_core failed");
        end
        $finish;
    end
endmodule

// ===== files.f =====
hdl/sahpwm_pkg.sv
hdl/six_axis_hbridge_pwm_drive_core.sv
tb/sv/tb_six_axis_hbridge_pwm_drive_core.sv
